// ===== rtl/core/prr_pkg.sv =====
// Shared field widths, request codes and reset item count for the permutation swap-remove ranker.
package prr_pkg;

	localparam int VALUE_W = 12;
	localparam int COUNT_W = 13;
	localparam int REQ_W   = 2;

	typedef logic [REQ_W-1:0]   req_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam req_t REQ_ENCODE  = 2'd0;
	localparam req_t REQ_DECODE  = 2'd1;
	localparam req_t REQ_RESTART = 2'd2;
	localparam req_t REQ_UNUSED  = 2'd3;

	localparam count_t NUM_ITEMS_RST = 13'd4096;

endpackage

// ===== rtl/core/prr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module prr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/permutation_swap_remove_ranker_core.sv =====
// Top level of the permutation swap-remove ranker: sequencer, count and both tables.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------------
//  request   | start in, busy out          | req_type, value
//  result    | done out (one-cycle strobe) | result_value, alphabet_size, error
//  config    | cfg_valid in, cfg_ready out | cfg_data (num_items)
//
// Steps: encode and decode read the last-code holder and the first table entry at
//   accept, read the dependent code-to-index entry, then check and write back; the
//   single read port of each table keeps these reads apart. An encode refused after
//   the lookup runs the same steps; requests refused before any lookup answer from idle.
// Restart sweeps both tables back to identity, one entry a cycle, then answers.
// Reset runs the same sweep with busy high and no result; config writes are taken
//   throughout.
// done pulses for one cycle with the result; the receiver cannot stall it.
module permutation_swap_remove_ranker_core #(
	parameter int MAX_ITEMS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  prr_pkg::req_t          req_type,
	input  prr_pkg::value_t        value,
	output logic                   done,
	output prr_pkg::value_t        result_value,
	output prr_pkg::count_t        alphabet_size,
	output logic                   error,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  prr_pkg::count_t        cfg_data
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int RW = $clog2(MAX_ITEMS + 1);
	localparam int CW = (RW > prr_pkg::COUNT_W) ? RW : prr_pkg::COUNT_W;
	localparam int REM_RST = (MAX_ITEMS < 4096) ? MAX_ITEMS : 4096;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_CHECK = 2'd3;

	logic [1:0]      state_q;
	prr_pkg::req_t   req_q;
	prr_pkg::value_t val_q;
	logic [AW-1:0]   code_q;
	logic [AW-1:0]   lh_q;
	logic [AW-1:0]   ptr_q;
	logic [RW-1:0]   rem_q;
	logic            restart_q;
	prr_pkg::count_t num_q;
	logic            done_q;
	prr_pkg::value_t res_q;
	prr_pkg::count_t alpha_q;
	logic            err_q;

	logic [RW-1:0]   items_eff;
	logic [RW-1:0]   rem_m1;
	logic [CW-1:0]   val_cw;
	logic [CW-1:0]   rem_cw;
	logic [CW-1:0]   eff_cw;
	logic            accept;
	logic            early_err;
	logic            chk_err;
	prr_pkg::value_t chk_res;

	logic            mem_we;
	logic [AW-1:0]   c2i_wa, c2i_wd, c2i_ra, c2i_rd;
	logic [AW-1:0]   i2c_wa, i2c_wd, i2c_ra, i2c_rd;

	// Saturate the configured count into 1..MAX_ITEMS.
	always_comb begin
		if (num_q == '0) begin
			items_eff = RW'(1);
		end else if (CW'(num_q) > CW'(MAX_ITEMS)) begin
			items_eff = RW'(MAX_ITEMS);
		end else begin
			items_eff = RW'(num_q);
		end
	end

	assign rem_m1 = rem_q - RW'(1);
	assign val_cw = CW'(value);
	assign rem_cw = CW'(rem_q);
	assign eff_cw = CW'(items_eff);
	assign accept = start && (state_q == ST_IDLE);

	// Refuse up front what needs no table lookup.
	assign early_err = (req_type == prr_pkg::REQ_UNUSED) || (rem_q == '0)
		|| ((req_type == prr_pkg::REQ_ENCODE) && (val_cw >= eff_cw))
		|| ((req_type == prr_pkg::REQ_DECODE) && (val_cw >= rem_cw));

	// Encode is valid only if the code is live and the code table still points back.
	assign chk_err = (req_q == prr_pkg::REQ_ENCODE)
		&& ((CW'(code_q) >= rem_cw) || (c2i_rd != AW'(val_q)));
	assign chk_res = (req_q == prr_pkg::REQ_ENCODE) ? prr_pkg::VALUE_W'(code_q)
		: prr_pkg::VALUE_W'(c2i_rd);

	// Read the last-code holder at accept; in LOOK read the code's owner entry.
	always_comb begin
		i2c_ra = AW'(value);
		if (state_q == ST_LOOK) begin
			c2i_ra = (req_q == prr_pkg::REQ_DECODE) ? AW'(val_q) : i2c_rd;
		end else begin
			c2i_ra = rem_m1[AW-1:0];
		end
	end

	// Write back the swap, or sweep identity during a clear.
	always_comb begin
		mem_we = (state_q == ST_CLEAR) || ((state_q == ST_CHECK) && !chk_err);
		if (state_q == ST_CLEAR) begin
			c2i_wa = ptr_q;
			c2i_wd = ptr_q;
			i2c_wa = ptr_q;
			i2c_wd = ptr_q;
		end else begin
			c2i_wa = code_q;
			c2i_wd = lh_q;
			i2c_wa = lh_q;
			i2c_wd = code_q;
		end
	end

	prr_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_c2i (
		.clk   (clk),
		.we    (mem_we),
		.waddr (c2i_wa),
		.wdata (c2i_wd),
		.raddr (c2i_ra),
		.rdata (c2i_rd)
	);

	prr_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_i2c (
		.clk   (clk),
		.we    (mem_we),
		.waddr (i2c_wa),
		.wdata (i2c_wd),
		.raddr (i2c_ra),
		.rdata (i2c_rd)
	);

	// Control state: sequencer, remaining count, sweep pointer, config register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			restart_q <= 1'b0;
			rem_q     <= RW'(REM_RST);
			num_q     <= prr_pkg::NUM_ITEMS_RST;
			done_q    <= 1'b0;
		end else begin
			// Strobe on an early refusal, a finished lookup or the end of a restart sweep.
			done_q <= (accept && (req_type != prr_pkg::REQ_RESTART) && early_err)
				|| (state_q == ST_CHECK)
				|| ((state_q == ST_CLEAR) && (ptr_q == AW'(MAX_ITEMS - 1)) && restart_q);
			if (cfg_valid) begin
				num_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == prr_pkg::REQ_RESTART) begin
							state_q   <= ST_CLEAR;
							ptr_q     <= '0;
							restart_q <= 1'b1;
							rem_q     <= items_eff;
						end else if (!early_err) begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_IDLE;
					if (!chk_err) begin
						rem_q <= rem_m1;
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == AW'(MAX_ITEMS - 1)) begin
						state_q   <= ST_IDLE;
						restart_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: latched request, lookup results and the outgoing item.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			val_q   <= value;
			res_q   <= '0;
			alpha_q <= prr_pkg::COUNT_W'(rem_q);
			err_q   <= 1'b1;
		end
		if (state_q == ST_LOOK) begin
			lh_q   <= c2i_rd;
			code_q <= (req_q == prr_pkg::REQ_DECODE) ? AW'(val_q) : i2c_rd;
		end
		if (state_q == ST_CHECK) begin
			res_q   <= chk_err ? '0 : chk_res;
			alpha_q <= prr_pkg::COUNT_W'(rem_q);
			err_q   <= chk_err;
		end
		if ((state_q == ST_CLEAR) && (ptr_q == AW'(MAX_ITEMS - 1))) begin
			res_q   <= '0;
			alpha_q <= '0;
			err_q   <= 1'b0;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign result_value  = res_q;
	assign alphabet_size = alpha_q;
	assign error         = err_q;

	// An accepted item either answers next cycle or keeps the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || busy))
		else $error("accepted item neither answered nor in progress");

	// A successful removal drops the remaining count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CHECK) && !chk_err) |=> (rem_q == $past(rem_m1)))
		else $error("remaining count not decremented on removal");

	// The remaining count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(rem_q) <= CW'(MAX_ITEMS)))
		else $error("remaining count above table depth");

	// Tables are written only by the sweep or the write-back step.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_CLEAR) || (state_q == ST_CHECK)))
		else $error("table write outside sweep or write-back");

endmodule

// ===== bench/permutation_swap_remove_ranker_core_tb.sv =====
// Self-checking testbench for the permutation swap-remove ranker core.
`timescale 1ns / 100ps

module permutation_swap_remove_ranker_core_tb;

	import prr_pkg::*;

	localparam int MAX_ITEMS   = 4096;
	// No item, result or config write for this long means the block has hung.
	// The limit must outlast both a restart sweep and the reset sweep.
	localparam int STALL_LIMIT = 20000;

	// One request as the sender presents it.
	typedef struct packed {
		req_t   kind;
		value_t operand;
	} rank_req_t;

	// One answer as the block reports it.
	typedef struct packed {
		value_t code;
		count_t alphabet;
		logic   refused;
	} rank_answer_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	req_t   req_type;
	value_t value;
	logic   done;
	value_t result_value;
	count_t alphabet_size;
	logic   error;
	logic   cfg_valid;
	logic   cfg_ready;
	count_t cfg_data;

	// Requests waiting for the driver, and answers waiting for the block.
	rank_req_t    outbound_reqs[$];
	rank_answer_t expected_answers[$];
	rank_req_t    next_req;
	logic         item_taken;
	int unsigned  idle_pct;

	// Predicted state of the ranker: both tables, live count and the raw register.
	value_t code_of_item[MAX_ITEMS];
	value_t item_at_code[MAX_ITEMS];
	count_t live_count;
	count_t items_cfg;

	int unsigned mismatches;
	int unsigned n_encode;
	int unsigned n_decode;
	int unsigned n_restart;
	int unsigned n_unused;
	int unsigned n_refused;
	int unsigned n_cfg_writes;
	int unsigned stall_cycles;

	permutation_swap_remove_ranker_core #(
		.MAX_ITEMS(MAX_ITEMS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.value        (value),
		.done         (done),
		.result_value (result_value),
		.alphabet_size(alphabet_size),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Clamp the register into 1..MAX_ITEMS, as the block does.
	function automatic count_t saturate_items(count_t raw);
		if (raw == '0)
			return count_t'(1);
		if (raw > count_t'(MAX_ITEMS))
			return count_t'(MAX_ITEMS);
		return raw;
	endfunction

	// Put both tables back to identity and refill the live count.
	function automatic void restore_identity();
		for (int i = 0; i < MAX_ITEMS; i++) begin
			code_of_item[i] = value_t'(i);
			item_at_code[i] = value_t'(i);
		end
		live_count = saturate_items(items_cfg);
	endfunction

	// Free code c: the item that holds the last live code moves into it.
	function automatic void swap_remove(value_t c);
		value_t last_holder;
		live_count  = live_count - count_t'(1);
		last_holder = item_at_code[live_count[VALUE_W-1:0]];
		code_of_item[last_holder] = c;
		item_at_code[c]           = last_holder;
	endfunction

	// Work out the answer to one request and advance the predicted state.
	function automatic rank_answer_t rank_request(req_t kind, value_t v);
		rank_answer_t ans;
		value_t       c;
		ans          = '0;
		ans.alphabet = live_count;
		if (kind == REQ_RESTART) begin
			restore_identity();
			ans.alphabet = '0;
		end else if (kind == REQ_UNUSED || live_count == '0) begin
			ans.refused = 1'b1;
		end else if (kind == REQ_ENCODE) begin
			c = code_of_item[v];
			// Refuse an index past the item count, or an item already removed:
			// its code is past the live range or the code no longer points back.
			if ({1'b0, v} >= saturate_items(items_cfg) || {1'b0, c} >= live_count ||
			    item_at_code[c] != v) begin
				ans.refused = 1'b1;
			end else begin
				swap_remove(c);
				ans.code = c;
			end
		end else begin
			if ({1'b0, v} >= live_count) begin
				ans.refused = 1'b1;
			end else begin
				ans.code = item_at_code[v];
				swap_remove(v);
			end
		end
		return ans;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: present queued items at the falling edge, hold until taken
	// ---------------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			// Advance to the next item unless the sender idles this cycle.
			if (outbound_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				next_req  = outbound_reqs.pop_front();
				start    <= 1'b1;
				req_type <= next_req.kind;
				value    <= next_req.operand;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: predict on every taken item, check every result strobe
	// ---------------------------------------------------------------------

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rank_answer_t want;
		if (arst_n) begin
			if (start && !busy) begin
				expected_answers.push_back(rank_request(req_type, value));
				case (req_type)
					REQ_ENCODE:  n_encode++;
					REQ_DECODE:  n_decode++;
					REQ_RESTART: n_restart++;
					default:     n_unused++;
				endcase
			end
			// The register is used by the encode range check and the next restart, so take it at once.
			if (cfg_valid && cfg_ready) begin
				items_cfg = cfg_data;
				n_cfg_writes++;
			end
			if (done) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: result with nothing outstanding, expected none, got %0d/%0d/%0d",
						$time, result_value, alphabet_size, error);
					mismatches++;
				end else begin
					want = expected_answers.pop_front();
					check_field("result_value", want.code, result_value);
					check_field("alphabet_size", want.alphabet, alphabet_size);
					check_field("error", want.refused, error);
					if (error)
						n_refused++;
				end
			end
		end
		item_taken <= arst_n && start && !busy;
	end

	// Drop the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("permutation_swap_remove_ranker_core_tb: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	task automatic push_req(req_t kind, value_t operand);
		rank_req_t r;
		r.kind    = kind;
		r.operand = operand;
		outbound_reqs.push_back(r);
	endtask

	// Hold until every item has gone out and every answer has come back.
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (outbound_reqs.size() != 0 || start || expected_answers.size() != 0 || busy);
	endtask

	task automatic write_num_items(count_t v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned phase_items;
		int unsigned frame_len;
		int unsigned n_eff;
		int unsigned pick;
		int unsigned slot;
		int          code_holders[$];
		count_t      cfg_val;
		count_t      gen_cfg;
		value_t      idx;

		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_ENCODE;
		value        = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		item_taken   = 1'b0;
		idle_pct     = 28;
		mismatches   = 0;
		n_encode     = 0;
		n_decode     = 0;
		n_restart    = 0;
		n_unused     = 0;
		n_refused    = 0;
		n_cfg_writes = 0;
		stall_cycles = 0;
		items_cfg    = NUM_ITEMS_RST;
		gen_cfg      = NUM_ITEMS_RST;
		restore_identity();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: full frame out of reset, top index and code first.
		push_req(REQ_ENCODE, 12'd4095);   // last code removes itself
		push_req(REQ_ENCODE, 12'd4095);   // already removed, code past live range
		push_req(REQ_DECODE, 12'd0);      // item 4094 moves into code 0
		push_req(REQ_DECODE, 12'd4094);   // code at the live count
		push_req(REQ_ENCODE, 12'd0);      // code table no longer points back
		push_req(REQ_ENCODE, 12'd4094);   // now holds code 0
		push_req(REQ_UNUSED, 12'd4095);
		push_req(REQ_RESTART, 12'd4095);

		// Smallest frame; the new count bounds encode at once but sets the live count only at the restart.
		wait_idle();
		write_num_items(count_t'(1));
		push_req(REQ_ENCODE, 12'd100);
		push_req(REQ_RESTART, 12'd0);
		push_req(REQ_ENCODE, 12'd0);
		push_req(REQ_ENCODE, 12'd0);      // empty table
		push_req(REQ_DECODE, 12'd0);      // empty table
		push_req(REQ_UNUSED, 12'd0);

		// Zero clamps to one item.
		wait_idle();
		write_num_items(count_t'(0));
		push_req(REQ_RESTART, 12'd0);
		push_req(REQ_DECODE, 12'd0);
		push_req(REQ_DECODE, 12'd0);

		// Short frame: index past the count, then empty it.
		wait_idle();
		write_num_items(count_t'(3));
		push_req(REQ_RESTART, 12'd0);
		push_req(REQ_ENCODE, 12'd3);
		push_req(REQ_ENCODE, 12'd2);
		push_req(REQ_DECODE, 12'd1);
		push_req(REQ_DECODE, 12'd0);
		push_req(REQ_ENCODE, 12'd1);

		// All-ones register clamps to the full table.
		wait_idle();
		write_num_items(count_t'(8191));
		push_req(REQ_RESTART, 12'd0);
		push_req(REQ_DECODE, 12'd4095);
		gen_cfg = count_t'(8191);

		// Random frames: sender idles 28%, then 71%, then never.
		for (int phase = 0; phase < 3; phase++) begin
			wait_idle();
			idle_pct    = (phase == 0) ? 28 : (phase == 1) ? 71 : 0;
			phase_items = 0;
			while (phase_items < 133) begin
				// Most frames reconfigure from idle; the rest restart mid-stream.
				if ($urandom_range(0, 99) < 70) begin
					wait_idle();
					pick = $urandom_range(0, 99);
					if (pick < 60) begin
						cfg_val = count_t'($urandom_range(1, 12));
					end else if (pick < 75) begin
						cfg_val = count_t'($urandom_range(13, 64));
					end else if (pick < 88) begin
						case ($urandom_range(0, 4))
							0:       cfg_val = count_t'(0);
							1:       cfg_val = count_t'(1);
							2:       cfg_val = NUM_ITEMS_RST;
							3:       cfg_val = count_t'(4097);
							default: cfg_val = count_t'(8191);
						endcase
					end else begin
						cfg_val = count_t'($urandom_range(0, 8191));
					end
					write_num_items(cfg_val);
					gen_cfg = cfg_val;
				end
				n_eff = saturate_items(gen_cfg);
				push_req(REQ_RESTART, value_t'($urandom));

				// Track which item holds each live code, to pick live targets.
				code_holders = {};
				for (int i = 0; i < n_eff; i++)
					code_holders.push_back(i);
				frame_len = (n_eff <= 40) ? n_eff + $urandom_range(0, 3) : $urandom_range(20, 60);
				repeat (frame_len) begin
					pick = $urandom_range(0, 99);
					if (pick < 85 && code_holders.size() != 0) begin
						slot = $urandom_range(0, code_holders.size() - 1);
						idx  = value_t'(code_holders[slot]);
						code_holders[slot] = code_holders[code_holders.size() - 1];
						code_holders.pop_back();
						if ($urandom_range(0, 1))
							push_req(REQ_ENCODE, idx);
						else
							push_req(REQ_DECODE, value_t'(slot));
					end else if (pick < 95) begin
						// Noise: any value, mostly out of range or already gone.
						push_req($urandom_range(0, 1) ? REQ_ENCODE : REQ_DECODE, value_t'($urandom));
					end else begin
						push_req(REQ_UNUSED, value_t'($urandom));
					end
				end
				phase_items += frame_len + 1;
			end
		end

		// Drain, then leave room for any stray strobe.
		wait_idle();
		repeat (16) @(posedge clk);

		$display("Covered %0d encode, %0d decode, %0d restart and %0d unused requests,",
			n_encode, n_decode, n_restart, n_unused);
		$display("%0d of them refused, over %0d item-count settings.", n_refused, n_cfg_writes);
		if (mismatches == 0) begin
			$display("permutation_swap_remove_ranker_core_tb: clean");
		end else begin
			$display("permutation_swap_remove_ranker_core_tb: errors");
		end
		$finish;
	end

endmodule
